>>> hdl/ed_pkg.sv
// Shared types and codes for the edit distance block.
`timescale 1ns / 1ps
package ed_pkg;
  localparam logic [1:0] OP_LOAD_SRC = 2'd0;
  localparam logic [1:0] OP_LOAD_TGT = 2'd1;
  localparam logic [1:0] OP_COMPUTE  = 2'd2;

  localparam logic [2:0] EOP_NONE   = 3'd0;
  localparam logic [2:0] EOP_MATCH  = 3'd1;
  localparam logic [2:0] EOP_SUBST  = 3'd2;
  localparam logic [2:0] EOP_INSERT = 3'd3;
  localparam logic [2:0] EOP_DELETE = 3'd4;

  localparam logic [1:0] CELL_DIAG = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_DEL  = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] character;
  } in_item_t;

  typedef struct packed {
    logic [2:0] edit_op;
    logic [5:0] distance;
    logic       overflow;
    logic       last;
  } out_item_t;
endpackage

>>> hdl/ed_if.sv
// Valid/ready channel interfaces for input and result items.
`timescale 1ns / 1ps
interface ed_in_if;
  logic            valid;
  logic            ready;
  ed_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ed_out_if;
  logic             valid;
  logic             ready;
  ed_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/ed_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module ed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/edit_distance_with_traceback.sv
// Top level of the edit distance block with traceback.
`timescale 1ns / 1ps
// Load items (append source or target byte) are taken in the idle state. A
// compute item runs a sequencer around one shared cell unit: for every table
// cell it reads the two characters and the previous row entry from the
// registered-read RAMs (read state, then write state). Traceback then walks
// back from the final cell, one step at a time (decide, op table read, push),
// pushing operations on a stack RAM. The stack is popped one result at a
// time (stack read, then hold the transaction until the consumer takes it).
// The block is not ready during a compute run. Lengths and the overflow flag
// clear at the end of the run. No clearing pass after reset.
module edit_distance_with_traceback #(
  parameter int MAX_LEN = 32
) (
  input logic     clk,
  input logic     rst,
  ed_in_if.sink   in_ch,
  ed_out_if.source out_ch
);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int RW = $clog2(MAX_LEN + 1);
  localparam int TD = MAX_LEN * MAX_LEN;
  localparam int TW = (TD > 1) ? $clog2(TD) : 1;
  localparam int SD = 2 * MAX_LEN;
  localparam int SW = $clog2(SD + 1);
  localparam int PW = $clog2(SD);

  typedef enum logic [3:0] {
    IDLE, INIT_ROW, ROW_START, CELL_RD, CELL_WR,
    TB_STEP, TB_RD, TB_USE, POP, EMIT
  } state_t;

  state_t          state;
  logic [LW-1:0]   src_len, tgt_len;
  logic            ovf_flag;
  logic [LW-1:0]   i, j;
  logic [5:0]      diag, left;
  logic [5:0]      edit_dist;
  logic            ovf_run;
  logic [SW-1:0]   sp;

  // RAM ports
  logic            src_we, tgt_we, row_we, tab_we;
  logic [AW-1:0]   src_wa, tgt_wa, src_ra, tgt_ra;
  logic [7:0]      src_rd, tgt_rd;
  logic [RW-1:0]   row_wa, row_ra;
  logic [5:0]      row_wd, row_rd;
  logic [TW-1:0]   tab_a, tab_ra;
  logic [1:0]      tab_wd, tab_rd;

  logic            accept;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == IDLE);

  assign src_we = accept && in_ch.payload.operation == ed_pkg::OP_LOAD_SRC
                  && src_len < LW'(MAX_LEN);
  assign tgt_we = accept && in_ch.payload.operation == ed_pkg::OP_LOAD_TGT
                  && tgt_len < LW'(MAX_LEN);
  assign src_wa = src_len[AW-1:0];
  assign tgt_wa = tgt_len[AW-1:0];

  // Index i-1, j-1 of the current cell (i,j >= 1 when used).
  logic [LW-1:0] im1, jm1;
  assign im1 = i - LW'(1);
  assign jm1 = j - LW'(1);
  assign src_ra = im1[AW-1:0];
  assign tgt_ra = jm1[AW-1:0];
  assign tab_a  = TW'(32'(im1) * MAX_LEN + 32'(jm1));
  assign tab_ra = tab_a;

  ed_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_src (
    .clk, .we(src_we), .waddr(src_wa), .wdata(in_ch.payload.character),
    .raddr(src_ra), .rdata(src_rd));
  ed_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_tgt (
    .clk, .we(tgt_we), .waddr(tgt_wa), .wdata(in_ch.payload.character),
    .raddr(tgt_ra), .rdata(tgt_rd));
  ed_ram #(.WIDTH(6), .DEPTH(MAX_LEN + 1)) u_row (
    .clk, .we(row_we), .waddr(row_wa), .wdata(row_wd),
    .raddr(row_ra), .rdata(row_rd));
  ed_ram #(.WIDTH(2), .DEPTH(TD)) u_tab (
    .clk, .we(tab_we), .waddr(tab_a), .wdata(tab_wd),
    .raddr(tab_ra), .rdata(tab_rd));

  // Shared cell unit: diagonal cost against left+1 and up+1.
  logic [6:0] c_diag, c_left, c_up, best;
  logic [1:0] sel;
  always_comb begin
    c_diag = 7'(diag) + 7'(src_rd != tgt_rd);
    c_left = 7'(left) + 7'd1;
    c_up   = 7'(row_rd) + 7'd1;
    best = c_diag;
    sel  = ed_pkg::CELL_DIAG;
    if (c_left < best) begin
      best = c_left;
      sel  = ed_pkg::CELL_INS;
    end
    if (c_up < best) begin
      best = c_up;
      sel  = ed_pkg::CELL_DEL;
    end
  end

  always_comb begin
    row_we = 1'b0;
    row_wa = RW'(j);
    row_wd = 6'(j);
    row_ra = RW'(j);
    tab_we = 1'b0;
    tab_wd = sel;
    case (state)
      INIT_ROW: begin
        row_we = 1'b1;
      end
      ROW_START: begin
        row_we = 1'b1;
        row_wa = '0;
        row_wd = 6'(i);
        row_ra = '0;
      end
      CELL_WR: begin
        row_we = 1'b1;
        row_wd = best[5:0];
        tab_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Traceback decision.
  logic [2:0] tb_op;
  always_comb begin
    if (i == '0) tb_op = ed_pkg::EOP_INSERT;
    else if (j == '0) tb_op = ed_pkg::EOP_DELETE;
    else begin
      case (tab_rd)
        ed_pkg::CELL_INS: tb_op = ed_pkg::EOP_INSERT;
        ed_pkg::CELL_DEL: tb_op = ed_pkg::EOP_DELETE;
        default: tb_op = (src_rd == tgt_rd) ? ed_pkg::EOP_MATCH
                                            : ed_pkg::EOP_SUBST;
      endcase
    end
  end

  logic [SW-1:0] spm1;
  assign spm1 = sp - SW'(1);

  // Operation stack: push in traceback, read the top ahead of each pop.
  logic          stk_we;
  logic [PW-1:0] stk_wa, stk_ra;
  logic [2:0]    stk_rd;
  assign stk_we = (state == TB_USE);
  assign stk_wa = sp[PW-1:0];
  assign stk_ra = spm1[PW-1:0];

  ed_ram #(.WIDTH(3), .DEPTH(SD)) u_stk (
    .clk, .we(stk_we), .waddr(stk_wa), .wdata(tb_op),
    .raddr(stk_ra), .rdata(stk_rd));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      src_len  <= '0;
      tgt_len  <= '0;
      ovf_flag <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (accept) begin
            case (in_ch.payload.operation)
              ed_pkg::OP_LOAD_SRC: begin
                if (src_len < LW'(MAX_LEN)) src_len <= src_len + LW'(1);
                else ovf_flag <= 1'b1;
              end
              ed_pkg::OP_LOAD_TGT: begin
                if (tgt_len < LW'(MAX_LEN)) tgt_len <= tgt_len + LW'(1);
                else ovf_flag <= 1'b1;
              end
              ed_pkg::OP_COMPUTE: begin
                ovf_run <= ovf_flag;
                j       <= '0;
                state   <= INIT_ROW;
              end
              default: ;
            endcase
          end
        end
        INIT_ROW: begin
          // Row zero: cost j at column j.
          if (j == tgt_len) begin
            edit_dist <= 6'(tgt_len);
            i     <= LW'(1);
            state <= (src_len == '0) ? TB_STEP : ROW_START;
            if (src_len == '0) begin
              i <= '0;
              j <= tgt_len;
              sp <= '0;
            end
          end else j <= j + LW'(1);
        end
        ROW_START: begin
          // Old entry 0 (i-1) is the new diag; hold i as the new left.
          diag  <= 6'(i - LW'(1));
          left  <= 6'(i);
          j     <= LW'(1);
          state <= (tgt_len == '0) ? ROW_START : CELL_RD;
          if (tgt_len == '0) begin
            if (i == src_len) begin
              edit_dist <= 6'(i);
              j     <= '0;
              sp    <= '0;
              state <= TB_STEP;
            end else i <= i + LW'(1);
          end
        end
        CELL_RD: state <= CELL_WR;
        CELL_WR: begin
          diag <= row_rd;
          left <= best[5:0];
          if (j == tgt_len) begin
            if (i == src_len) begin
              edit_dist <= best[5:0];
              sp    <= '0;
              state <= TB_STEP;
            end else begin
              i     <= i + LW'(1);
              state <= ROW_START;
            end
          end else begin
            j     <= j + LW'(1);
            state <= CELL_RD;
          end
        end
        TB_STEP: begin
          if (i == '0 && j == '0) begin
            out_ch.payload.distance <= edit_dist;
            out_ch.payload.overflow <= ovf_run;
            if (sp == '0) begin
              // Both strings empty: one transaction with no edit.
              out_ch.valid <= 1'b1;
              out_ch.payload.edit_op <= ed_pkg::EOP_NONE;
              out_ch.payload.last    <= 1'b1;
              state <= EMIT;
            end else state <= POP;
          end else state <= TB_RD;
        end
        TB_RD: state <= TB_USE;
        TB_USE: begin
          sp <= sp + SW'(1);
          if (tb_op == ed_pkg::EOP_INSERT) j <= jm1;
          else if (tb_op == ed_pkg::EOP_DELETE) i <= im1;
          else begin
            i <= im1;
            j <= jm1;
          end
          state <= TB_STEP;
        end
        POP: begin
          // Stack top has been read; present it.
          out_ch.valid <= 1'b1;
          out_ch.payload.edit_op <= stk_rd;
          out_ch.payload.last    <= (sp == SW'(1));
          sp    <= spm1;
          state <= EMIT;
        end
        EMIT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            if (out_ch.payload.last) begin
              src_len  <= '0;
              tgt_len  <= '0;
              ovf_flag <= 1'b0;
              state    <= IDLE;
            end else begin
              state <= POP;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // Results only leave in the emit state.
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> state == EMIT) else $error("result outside emit");
  // Loads never run past the string capacity.
  assert property (@(posedge clk) disable iff (rst)
    src_len <= LW'(MAX_LEN) && tgt_len <= LW'(MAX_LEN))
    else $error("length overrun");
  // A final result ends the run and clears the lengths.
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && out_ch.payload.last |=>
      state == IDLE && src_len == '0 && tgt_len == '0)
    else $error("run did not close");
endmodule

>>> dv/edit_distance_with_traceback_tb.sv
// Testbench for the edit distance block: random loads and computes, traceback checked.
`timescale 1ns / 1ps
module edit_distance_with_traceback_tb;

  localparam int MAX_LEN = 32;
  localparam int CYCLE_LIMIT = 2000000;

  // Scoreboard: keeps its own copy of the strings and predicts every traceback.
  class edit_scoreboard;
    logic [7:0] src_chars[$];
    logic [7:0] tgt_chars[$];
    bit         dropped;
    ed_pkg::out_item_t pending[$];
    int         mismatches;

    function new();
      dropped = 0;
      mismatches = 0;
    endfunction

    // Note an accepted input transaction and queue the results it causes.
    function void note_input(ed_pkg::in_item_t it);
      logic [5:0] row[0:MAX_LEN];
      logic [1:0] choice[0:MAX_LEN-1][0:MAX_LEN-1];
      logic [2:0] ops[$];
      logic [5:0] diag, up, best;
      logic [1:0] sel;
      logic [5:0] edit_dist;
      ed_pkg::out_item_t r;
      int sl, tl, i, j;
      if (it.operation == ed_pkg::OP_LOAD_SRC) begin
        if (src_chars.size() < MAX_LEN) src_chars.push_back(it.character);
        else dropped = 1;
        return;
      end
      if (it.operation == ed_pkg::OP_LOAD_TGT) begin
        if (tgt_chars.size() < MAX_LEN) tgt_chars.push_back(it.character);
        else dropped = 1;
        return;
      end
      if (it.operation != ed_pkg::OP_COMPUTE) return;
      sl = src_chars.size();
      tl = tgt_chars.size();
      for (j = 0; j <= tl; j++) row[j] = 6'(j);
      for (i = 1; i <= sl; i++) begin
        diag = row[0];
        row[0] = 6'(i);
        for (j = 1; j <= tl; j++) begin
          up = row[j];
          best = diag + 6'(src_chars[i-1] != tgt_chars[j-1]);
          sel = ed_pkg::CELL_DIAG;
          if (row[j-1] + 6'd1 < best) begin
            best = row[j-1] + 6'd1;
            sel = ed_pkg::CELL_INS;
          end
          if (up + 6'd1 < best) begin
            best = up + 6'd1;
            sel = ed_pkg::CELL_DEL;
          end
          diag = up;
          row[j] = best;
          choice[i-1][j-1] = sel;
        end
      end
      edit_dist = row[tl];
      i = sl;
      j = tl;
      while (i > 0 || j > 0) begin
        if (i == 0 || (j > 0 && choice[i-1][j-1] == ed_pkg::CELL_INS)) begin
          ops.push_front(ed_pkg::EOP_INSERT);
          j--;
        end else if (j == 0 || choice[i-1][j-1] == ed_pkg::CELL_DEL) begin
          ops.push_front(ed_pkg::EOP_DELETE);
          i--;
        end else begin
          ops.push_front(src_chars[i-1] == tgt_chars[j-1] ? ed_pkg::EOP_MATCH
                                                          : ed_pkg::EOP_SUBST);
          i--;
          j--;
        end
      end
      if (ops.size() == 0) ops.push_back(ed_pkg::EOP_NONE);
      foreach (ops[k]) begin
        r.edit_op = ops[k];
        r.distance = edit_dist;
        r.overflow = dropped;
        r.last = (k == ops.size() - 1);
        pending.push_back(r);
      end
      src_chars.delete();
      tgt_chars.delete();
      dropped = 0;
    endfunction

    // Compare one accepted result transaction with the oldest expectation.
    function void check_result(ed_pkg::out_item_t got);
      ed_pkg::out_item_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got.edit_op !== exp_r.edit_op || got.distance !== exp_r.distance ||
          got.overflow !== exp_r.overflow || got.last !== exp_r.last) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p, got %p", exp_r, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  ed_in_if  in_ch();
  ed_out_if out_ch();
  edit_distance_with_traceback #(.MAX_LEN(MAX_LEN)) dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  edit_scoreboard sb = new();
  int cycles = 0;
  bit no_stall = 0;

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.payload = '0;
    out_ch.ready = 0;
  end

  // Abort on a hang.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Sink side: check every accepted result and stall at random.
  int ready_wait = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
      if (out_ch.ready && out_ch.valid) begin
        ready_wait = no_stall ? 0 : $urandom_range(0, 6);
      end
      if (ready_wait > 0) begin
        ready_wait--;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  // Hand one transaction over, after a random gap, and wait for acceptance.
  // Valid stays high after acceptance until the next call or drain() drops or reuses it.
  task automatic send(logic [1:0] op, logic [7:0] ch);
    int gap;
    ed_pkg::in_item_t it;
    gap = no_stall ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    it.operation = op;
    it.character = ch;
    in_ch.valid <= 1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
  endtask

  // Load two strings with bytes from 0 to alpha; a small alpha makes matches common.
  task automatic send_pair(int sl, int tl, int alpha);
    int n;
    n = 0;
    while (n < sl + tl) begin
      if ($urandom_range(0, 1) && n < sl + tl) begin
        send(ed_pkg::OP_LOAD_SRC, 8'($urandom_range(0, alpha)));
      end else begin
        send(ed_pkg::OP_LOAD_TGT, 8'($urandom_range(0, alpha)));
      end
      n++;
    end
    send(ed_pkg::OP_COMPUTE, 8'($urandom));
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    int k, kind;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: both strings empty, then extreme bytes and one-sided strings.
    send(ed_pkg::OP_COMPUTE, 8'hFF);
    send(ed_pkg::OP_LOAD_SRC, 8'h00);
    send(ed_pkg::OP_LOAD_TGT, 8'hFF);
    send(ed_pkg::OP_COMPUTE, 8'h00);
    send(ed_pkg::OP_LOAD_SRC, 8'hAA);
    send(ed_pkg::OP_LOAD_SRC, 8'h55);
    send(ed_pkg::OP_COMPUTE, 8'h00);
    send(ed_pkg::OP_LOAD_TGT, 8'h5A);
    send(ed_pkg::OP_LOAD_TGT, 8'hA5);
    send(2'd3, 8'h12);         // unused code: ignored
    send(ed_pkg::OP_COMPUTE, 8'h00);
    send(ed_pkg::OP_LOAD_SRC, 8'h41);
    send(ed_pkg::OP_LOAD_TGT, 8'h41);
    send(ed_pkg::OP_COMPUTE, 8'h00);

    // Hold the sender until all results are back, then run one pair with no stalls at all.
    drain();
    no_stall = 1;
    send_pair(3, 4, 3);
    drain();
    no_stall = 0;

    // Full strings plus overflow on both sides.
    for (k = 0; k < MAX_LEN + 1; k++)
      send(ed_pkg::OP_LOAD_SRC, 8'($urandom_range(0, 1)));
    for (k = 0; k < MAX_LEN + 2; k++)
      send(ed_pkg::OP_LOAD_TGT, 8'($urandom_range(0, 1)));
    send(ed_pkg::OP_COMPUTE, 8'd0);

    // Random part: mostly short well-formed pairs, some noise.
    for (k = 0; k < 90; k++) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) send_pair($urandom_range(0, 4), $urandom_range(0, 4),
                              $urandom_range(0, 1) ? 3 : 255);
      else if (kind < 9) send(2'($urandom_range(0, 3)), 8'($urandom));
      else send_pair($urandom_range(0, 8), $urandom_range(0, 8), 255);
    end
    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> sim.f
hdl/ed_pkg.sv
hdl/ed_if.sv
hdl/ed_ram.sv
hdl/edit_distance_with_traceback.sv
dv/edit_distance_with_traceback_tb.sv
